>>> rtl/lfsa_pkg.sv
// Shared types, constants and a helper function of the lowest free slot allocator.
package lfsa_pkg;

  // Default sizes of the slot map and the car table
  localparam int MAX_SLOTS_DEF = 1024;
  localparam int MAX_CARS_DEF  = 1024;

  // Field widths
  localparam int CFG_W   = 6;
  localparam int CAR_W   = 10;
  localparam int TIME_W  = 32;
  localparam int ROW_W   = 5;
  localparam int COL_W   = 5;
  localparam int LANE_W  = 6;
  localparam int CNT_W   = 13;

  // Stream payload widths, padded to whole bytes
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 56;

  // APB port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // Register reset values
  localparam logic [CFG_W-1:0] LOT_WIDTH_RST  = 6'd32;
  localparam logic [CFG_W-1:0] LOT_HEIGHT_RST = 6'd32;

  // Register indexes (address bit 2)
  localparam logic REG_LOT_WIDTH  = 1'b0;
  localparam logic REG_LOT_HEIGHT = 1'b1;

  // Request kinds
  localparam logic REQ_LEAVE  = 1'b0;
  localparam logic REQ_ARRIVE = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_FIND,
    ST_FREE,
    ST_DIV,
    ST_EMIT
  } state_e;

  // Parking slots per row: width minus one driving lane per three columns.
  // (w+2)/3 is done as a multiply by 43 and a shift, exact for w+2 below 128.
  function automatic logic [LANE_W-1:0] lane_slots(input logic [CFG_W-1:0] w);
    logic [6:0]  x;
    logic [13:0] p;
    x = {1'b0, w} + 7'd2;
    p = 14'(x) * 14'd43;
    if (w < 6'd2) begin
      return '0;
    end
    return w - p[12:7];
  endfunction

endpackage

>>> rtl/lowest_free_slot_allocator.sv
// Top level of the lowest free slot allocator: sequencer, slot map, car table, APB registers.
//
// Parking allocator for time-ordered arrive and leave events.
// Input stream: s_axis_tuser carries the request kind (1 arrives, 0 leaves), s_axis_tdata
// the car number and the time stamp. An arriving car gets the lowest free slot below the
// slot count set by lot_width and lot_height; a leaving car frees its slot. Each placement
// or release gives one item on the output stream with car, row, column, time and the
// departing flag in m_axis_tuser. Refused or ignored requests give no item.
// Registers: lot_width at address 0, lot_height at address 4, written over APB; the user
// must write them only while idle, as the block itself does not enforce it.
// Flow: an accepted item goes through lookup, then find for an arrival or free for a leave,
// then the divider, then emit, where the output register is loaded; the input is ready
// again once the block is back in idle. The row/column mapping runs on a restoring divider
// that resolves one quotient bit per cycle. A refused or ignored request frees the input
// again from lookup or find. One item is in work at a time.
// Reset: registers go to 32 x 32, the slot map is marked free at once via per-row flags,
// and the car table is swept clear, one entry per cycle, while s_axis_tready is low.
// Stall: a finished result waits in the output register until m_axis_tready; the block
// holds the next result until that register is free.
module lowest_free_slot_allocator
  import lfsa_pkg::*;
#(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF,
  parameter int MAX_CARS  = MAX_CARS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Input stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [9:0] car_id, [41:10] event_time, [47:42] zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // [0] req_type
  input  logic                   s_axis_tuser,
  // Output stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [9:0] out_car, [14:10] slot_row, [19:15] slot_column, [51:20] out_time, [55:52] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // [0] departing
  output logic                   m_axis_tuser,
  // Configuration
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_AW-1:0]      paddr,
  input  logic [APB_DW-1:0]      pwdata,
  output logic [APB_DW-1:0]      prdata,
  output logic                   pready
);

  // Sizes
  localparam int CAW    = $clog2(MAX_CARS);
  localparam int CXW    = (CAW + 1 > CAR_W) ? CAW + 1 : CAR_W;
  localparam int WAW    = ($clog2(MAX_SLOTS) > 9) ? $clog2(MAX_SLOTS) - 5 : 4;
  localparam int WORD_W = 1 << WAW;
  localparam int ROWS   = (MAX_SLOTS + WORD_W - 1) / WORD_W;
  localparam int RAW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int SLOT_W = RAW + WAW;
  localparam int ENT_W  = SLOT_W + 1;

  state_e state_q, state_d;

  // Configuration registers
  logic [CFG_W-1:0] lot_width_q;
  logic [CFG_W-1:0] lot_height_q;
  logic             cfg_wr;

  // Request registers
  logic              type_q;
  logic [CAR_W-1:0]  car_q;
  logic [TIME_W-1:0] time_q;
  logic [SLOT_W-1:0] slot_q;
  logic [CAW-1:0]    clr_q;

  // Car table: valid bit over slot index
  logic [ENT_W-1:0] car_mem [MAX_CARS];
  logic [ENT_W-1:0] car_rd_q;
  logic             car_re;
  logic [CAW-1:0]   car_raddr;
  logic             car_we;
  logic [CAW-1:0]   car_waddr;
  logic [ENT_W-1:0] car_wdata;

  // Slot map: one used bit per slot, a row per word
  logic [WORD_W-1:0] slot_mem [ROWS];
  logic [WORD_W-1:0] slot_rd_q;
  logic              slot_re;
  logic [RAW-1:0]    slot_raddr;
  logic              slot_we;
  logic [RAW-1:0]    slot_waddr;
  logic [WORD_W-1:0] slot_wdata;
  logic [ROWS-1:0]   row_valid_q;
  logic [ROWS-1:0]   row_full_q;

  // Output register
  logic                   m_valid_q;
  logic [OUT_TDATA_W-1:0] m_data_q;
  logic                   m_user_q;
  logic                   out_load;

  // Divider hookup
  logic              div_start;
  logic [SLOT_W-1:0] div_dividend;
  logic              div_busy;
  logic [SLOT_W-1:0] div_quot;
  logic [LANE_W-1:0] div_rem;

  // Derived values
  logic [LANE_W-1:0] lane_k;
  logic [CNT_W-1:0]  slot_cnt;
  logic [CXW-1:0]    car_ext;
  logic [CXW-1:0]    in_car_ext;
  logic              car_in_range;
  logic [CAW-1:0]    car_idx;
  logic              ent_valid;
  logic [RAW-1:0]    free_row;
  logic              row_avail;
  logic [RAW-1:0]    cur_row;
  logic [WAW-1:0]    cur_bit;
  logic [WORD_W-1:0] word_used;
  logic [WAW-1:0]    zero_bit;
  logic              bit_avail;
  logic [SLOT_W-1:0] slot_found;
  logic              alloc_ok;
  logic [SLOT_W-1:0] quot_inc;
  logic [6:0]        col_sum;
  logic [ROW_W-1:0]  out_row;
  logic [COL_W-1:0]  out_col;

  // Lot geometry
  assign lane_k   = lane_slots(lot_width_q);
  assign slot_cnt = (lot_height_q < 6'd2) ? '0 :
                    CNT_W'(lot_height_q - 6'd1) * CNT_W'(lane_k);

  // Car number decoding
  assign car_ext      = CXW'(car_q);
  assign in_car_ext   = CXW'(s_axis_tdata[CAR_W-1:0]);
  assign car_in_range = (car_ext < CXW'(MAX_CARS));
  assign car_idx      = car_ext[CAW-1:0];
  assign ent_valid    = car_rd_q[ENT_W-1];

  // Lowest row that still has a free slot
  always_comb begin
    free_row  = '0;
    row_avail = 1'b0;
    for (int r = ROWS - 1; r >= 0; r--) begin
      if (!row_full_q[r]) begin
        free_row  = RAW'(r);
        row_avail = 1'b1;
      end
    end
  end

  // Row word as read; a row never written holds no used slot
  assign cur_row   = slot_q[SLOT_W-1:WAW];
  assign cur_bit   = slot_q[WAW-1:0];
  assign word_used = row_valid_q[cur_row] ? slot_rd_q : '0;

  // Lowest free bit in the row
  always_comb begin
    zero_bit  = '0;
    bit_avail = 1'b0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (!word_used[b]) begin
        zero_bit  = WAW'(b);
        bit_avail = 1'b1;
      end
    end
  end

  assign slot_found = {cur_row, zero_bit};
  assign alloc_ok   = bit_avail && (CNT_W'(slot_found) < CNT_W'(MAX_SLOTS)) &&
                      (CNT_W'(slot_found) < slot_cnt);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_q == CAW'(MAX_CARS - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_axis_tvalid) state_d = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        if (!car_in_range) begin
          state_d = ST_IDLE;
        end else if (type_q == REQ_ARRIVE) begin
          state_d = (ent_valid || !row_avail) ? ST_IDLE : ST_FIND;
        end else begin
          state_d = ent_valid ? ST_FREE : ST_IDLE;
        end
      end
      ST_FIND: begin
        state_d = alloc_ok ? ST_DIV : ST_IDLE;
      end
      ST_FREE: begin
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (!div_busy) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!m_valid_q || m_axis_tready) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control outputs
  always_comb begin
    s_axis_tready = 1'b0;
    car_re        = 1'b0;
    car_raddr     = in_car_ext[CAW-1:0];
    car_we        = 1'b0;
    car_waddr     = car_idx;
    car_wdata     = '0;
    slot_re       = 1'b0;
    slot_raddr    = free_row;
    slot_we       = 1'b0;
    slot_waddr    = cur_row;
    slot_wdata    = word_used;
    div_start     = 1'b0;
    div_dividend  = slot_q;
    out_load      = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        car_we    = 1'b1;
        car_waddr = clr_q;
      end
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        car_re        = s_axis_tvalid;
      end
      ST_LOOKUP: begin
        slot_re    = 1'b1;
        slot_raddr = (type_q == REQ_ARRIVE) ? free_row : car_rd_q[SLOT_W-1:WAW];
      end
      ST_FIND: begin
        slot_we      = alloc_ok;
        slot_wdata   = word_used | (WORD_W'(1) << zero_bit);
        car_we       = alloc_ok;
        car_wdata    = {1'b1, slot_found};
        div_start    = alloc_ok;
        div_dividend = slot_found;
      end
      ST_FREE: begin
        slot_we    = 1'b1;
        slot_wdata = word_used & ~(WORD_W'(1) << cur_bit);
        car_we     = 1'b1;
        car_wdata  = '0;
        div_start  = 1'b1;
      end
      ST_DIV: begin
      end
      ST_EMIT: begin
        out_load = !m_valid_q || m_axis_tready;
      end
      default: begin
      end
    endcase
  end

  // State, configuration and slot map flags
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_q        <= '0;
      lot_width_q  <= LOT_WIDTH_RST;
      lot_height_q <= LOT_HEIGHT_RST;
      row_valid_q  <= '0;
      row_full_q   <= '0;
      m_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + CAW'(1);
      if (cfg_wr) begin
        unique case (paddr[2])
          REG_LOT_WIDTH:  lot_width_q  <= pwdata[CFG_W-1:0];
          REG_LOT_HEIGHT: lot_height_q <= pwdata[CFG_W-1:0];
          default: begin
          end
        endcase
      end
      if (slot_we) begin
        row_valid_q[slot_waddr] <= 1'b1;
        row_full_q[slot_waddr]  <= &slot_wdata;
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Request capture and slot under work
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && s_axis_tvalid) begin
      type_q <= s_axis_tuser;
      car_q  <= s_axis_tdata[CAR_W-1:0];
      time_q <= s_axis_tdata[CAR_W +: TIME_W];
    end
    if (state_q == ST_LOOKUP) begin
      slot_q <= (type_q == REQ_ARRIVE) ? {free_row, WAW'(0)} : car_rd_q[SLOT_W-1:0];
    end
  end

  // Car table memory
  always_ff @(posedge clk_i) begin
    if (car_we) car_mem[car_waddr] <= car_wdata;
    if (car_re) car_rd_q <= car_mem[car_raddr];
  end

  // Slot map memory
  always_ff @(posedge clk_i) begin
    if (slot_we) slot_mem[slot_waddr] <= slot_wdata;
    if (slot_re) slot_rd_q <= slot_mem[slot_raddr];
  end

  // Slot index to row and lane position
  lfsa_divider #(
    .DW(SLOT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (lane_k),
    .busy_o     (div_busy),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // Row is quotient plus one; column skips one driving lane per two slots
  assign quot_inc = div_quot + SLOT_W'(1);
  assign col_sum  = {1'b0, div_rem} + (({1'b0, div_rem} + 7'd1) >> 1);
  assign out_row  = (lane_k == '0) ? '0 : quot_inc[ROW_W-1:0];
  assign out_col  = (lane_k == '0) ? '0 : col_sum[COL_W-1:0];

  // Output register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= {4'b0, time_q, out_col, out_row, car_q};
      m_user_q <= (type_q == REQ_LEAVE);
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  // Register read-back
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_LOT_HEIGHT) ? APB_DW'(lot_height_q) : APB_DW'(lot_width_q);

endmodule

>>> rtl/lfsa_divider.sv
// Restoring divider: one quotient bit per cycle, used to map a slot index to row and column.
module lfsa_divider
  import lfsa_pkg::*;
#(
  parameter int DW = 10
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DW-1:0]     dividend_i,
  input  logic [LANE_W-1:0] divisor_i,
  output logic              busy_o,
  output logic [DW-1:0]     quot_o,
  output logic [LANE_W-1:0] rem_o
);

  localparam int CW = $clog2(DW + 1);

  logic [CW-1:0]     cnt_q, cnt_d;
  logic [DW-1:0]     quo_q, quo_d;
  logic [LANE_W-1:0] rem_q, rem_d;
  logic [LANE_W-1:0] div_q, div_d;

  logic [LANE_W:0] trial;
  logic [LANE_W:0] diff;
  logic            ge;

  // One subtract-and-compare step
  assign trial = {rem_q, quo_q[DW-1]};
  assign diff  = trial - {1'b0, div_q};
  assign ge    = (trial >= {1'b0, div_q});

  always_comb begin
    cnt_d = cnt_q;
    quo_d = quo_q;
    rem_d = rem_q;
    div_d = div_q;
    if (start_i) begin
      cnt_d = CW'(DW);
      quo_d = dividend_i;
      rem_d = '0;
      div_d = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - CW'(1);
      quo_d = {quo_q[DW-2:0], ge};
      rem_d = ge ? diff[LANE_W-1:0] : trial[LANE_W-1:0];
    end
  end

  // Step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign busy_o = (cnt_q != '0);
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule
